// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the 2D FFT core.
// Needs nothing else; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== src/fft2d_pkg.sv =====
// Shared constants, command and status types and arithmetic helpers
// for the 2D FFT core. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package fft2d_pkg;

  localparam int WIDTH      = 8;
  localparam int HEIGHT     = 8;
  localparam int WIDTH_LOG  = 3;
  localparam int HEIGHT_LOG = 3;
  localparam int DEPTH      = 64;
  localparam int ADDR_W     = 6;
  localparam int CNT_W      = 7;
  localparam int LOG_W      = 2;
  localparam int POS_W      = 3;
  localparam int TW_LOG     = 3;
  localparam int DATA_W     = 32;
  localparam int TW_W       = 18;
  localparam int PROD_W     = 50;
  localparam int TRI_W      = 35;
  localparam int SUM_W      = 36;

  localparam logic [1:0] REG_INVERSE    = 2'd0;
  localparam logic [1:0] REG_WIDTH_LOG  = 2'd1;
  localparam logic [1:0] REG_HEIGHT_LOG = 2'd2;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_LOAD,
    WR_SWAP_LO,
    WR_SWAP_HI,
    WR_BFLY_A,
    WR_BFLY_C
  } wr_sel_e;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr0;
    logic [ADDR_W-1:0] rd_addr1;
    wr_sel_e           wr_sel;
    logic [ADDR_W-1:0] wr_addr;
    logic              mul_en;
    logic              rnd_en;
    logic [1:0]        tw_idx;
    logic              inverse;
    logic              scale_en;
    logic [LOG_W-1:0]  scale_sh;
    logic              out_load;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic logic [LOG_W-1:0] fit_log(input logic [LOG_W-1:0] lg,
                                               input int lim);
    if (int'(lg) > lim) return LOG_W'(lim);
    return lg;
  endfunction

  function automatic logic [POS_W-1:0] bit_rev(input logic [POS_W-1:0] pos,
                                               input logic [LOG_W-1:0] lg);
    logic [POS_W-1:0] r;
    for (int b = 0; b < POS_W; b++) r[b] = pos[POS_W-1-b];
    return r >> (POS_W - int'(lg));
  endfunction

  function automatic logic signed [TW_W-1:0] tw_re(input logic [1:0] idx);
    case (idx)
      2'd0:    return 18'sd65536;
      2'd1:    return 18'sd46341;
      2'd2:    return 18'sd0;
      default: return -18'sd46341;
    endcase
  endfunction

  function automatic logic signed [TW_W-1:0] tw_im(input logic [1:0] idx,
                                                   input logic inv);
    logic signed [TW_W-1:0] s;
    case (idx)
      2'd0:    s = 18'sd0;
      2'd1:    s = -18'sd46341;
      2'd2:    s = -18'sd65536;
      default: s = -18'sd46341;
    endcase
    return inv ? -s : s;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[DATA_W-1:0];
  endfunction

  // round to nearest, ties up; sh is at least one
  function automatic logic signed [DATA_W-1:0] round_scale(input logic signed [DATA_W-1:0] x,
                                                           input logic [LOG_W-1:0] sh);
    logic signed [DATA_W:0] v;
    v = (DATA_W+1)'(x) + ((DATA_W+1)'(1) << (sh - 2'd1));
    return DATA_W'(v >>> sh);
  endfunction

endpackage
`default_nettype wire

// ===== src/fft2d_datapath.sv =====
// Datapath of the 2D FFT core: frame memory, butterfly arithmetic and
// output register. Driven by fft2d_ctrl through fft2d_pkg::cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module fft2d_datapath (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire fft2d_pkg::cmd_t                       cmd_i,
  output fft2d_pkg::stat_t                           stat_o,
  input  wire logic signed [fft2d_pkg::DATA_W-1:0]   sample_real_i,
  input  wire logic signed [fft2d_pkg::DATA_W-1:0]   sample_imag_i,
  input  wire logic                                  out_stall_i,
  output logic                                       out_valid_o,
  output logic signed [fft2d_pkg::DATA_W-1:0]        out_real_o,
  output logic signed [fft2d_pkg::DATA_W-1:0]        out_imag_o,
  output logic                                       last_of_frame_o
);

  localparam int DW = fft2d_pkg::DATA_W;

  logic [2*DW-1:0] mem_q [fft2d_pkg::DEPTH];
  logic [2*DW-1:0] rd0_q, rd1_q, wr_data, cres_q;

  logic signed [fft2d_pkg::TW_W-1:0]   wr, wi;
  logic signed [DW-1:0]                cre, cim;
  logic signed [DW-1:0]                ur_q, ui_q;
  logic signed [fft2d_pkg::PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [fft2d_pkg::PROD_W:0]   tr_sum, ti_sum;
  logic signed [fft2d_pkg::TRI_W-1:0]  tr_q, ti_q;
  logic signed [DW-1:0]                a_re, a_im, c_re, c_im;
  logic                                out_valid_q, out_last_q;
  logic signed [DW-1:0]                out_re_q, out_im_q;

  assign wr  = fft2d_pkg::tw_re(cmd_i.tw_idx);
  assign wi  = fft2d_pkg::tw_im(cmd_i.tw_idx, cmd_i.inverse);
  assign cre = $signed(rd1_q[2*DW-1:DW]);
  assign cim = $signed(rd1_q[DW-1:0]);

  assign tr_sum = (fft2d_pkg::PROD_W+1)'(p_rr_q) - (fft2d_pkg::PROD_W+1)'(p_ii_q)
                + (fft2d_pkg::PROD_W+1)'(32768);
  assign ti_sum = (fft2d_pkg::PROD_W+1)'(p_ri_q) + (fft2d_pkg::PROD_W+1)'(p_ir_q)
                + (fft2d_pkg::PROD_W+1)'(32768);

  always_comb begin
    logic signed [DW-1:0] sar, sai, scr, sci;
    sar = fft2d_pkg::sat32(fft2d_pkg::SUM_W'(ur_q) + fft2d_pkg::SUM_W'(tr_q));
    sai = fft2d_pkg::sat32(fft2d_pkg::SUM_W'(ui_q) + fft2d_pkg::SUM_W'(ti_q));
    scr = fft2d_pkg::sat32(fft2d_pkg::SUM_W'(ur_q) - fft2d_pkg::SUM_W'(tr_q));
    sci = fft2d_pkg::sat32(fft2d_pkg::SUM_W'(ui_q) - fft2d_pkg::SUM_W'(ti_q));
    // fold the inverse scaling into the final stage
    if (cmd_i.scale_en) begin
      a_re = fft2d_pkg::round_scale(sar, cmd_i.scale_sh);
      a_im = fft2d_pkg::round_scale(sai, cmd_i.scale_sh);
      c_re = fft2d_pkg::round_scale(scr, cmd_i.scale_sh);
      c_im = fft2d_pkg::round_scale(sci, cmd_i.scale_sh);
    end else begin
      a_re = sar;
      a_im = sai;
      c_re = scr;
      c_im = sci;
    end
  end

  always_comb begin
    case (cmd_i.wr_sel)
      fft2d_pkg::WR_LOAD:    wr_data = {sample_real_i, sample_imag_i};
      fft2d_pkg::WR_SWAP_LO: wr_data = rd1_q;
      fft2d_pkg::WR_SWAP_HI: wr_data = rd0_q;
      fft2d_pkg::WR_BFLY_A:  wr_data = {a_re, a_im};
      fft2d_pkg::WR_BFLY_C:  wr_data = cres_q;
      default:               wr_data = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_sel != fft2d_pkg::WR_NONE) begin
      mem_q[cmd_i.wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd0_q <= mem_q[cmd_i.rd_addr0];
      rd1_q <= mem_q[cmd_i.rd_addr1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      ur_q   <= $signed(rd0_q[2*DW-1:DW]);
      ui_q   <= $signed(rd0_q[DW-1:0]);
      p_rr_q <= fft2d_pkg::PROD_W'(wr) * fft2d_pkg::PROD_W'(cre);
      p_ii_q <= fft2d_pkg::PROD_W'(wi) * fft2d_pkg::PROD_W'(cim);
      p_ri_q <= fft2d_pkg::PROD_W'(wr) * fft2d_pkg::PROD_W'(cim);
      p_ir_q <= fft2d_pkg::PROD_W'(wi) * fft2d_pkg::PROD_W'(cre);
    end
    if (cmd_i.rnd_en) begin
      tr_q <= fft2d_pkg::TRI_W'(tr_sum >>> 16);
      ti_q <= fft2d_pkg::TRI_W'(ti_sum >>> 16);
    end
    if (cmd_i.wr_sel == fft2d_pkg::WR_BFLY_A) begin
      cres_q <= {c_re, c_im};
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_re_q   <= $signed(rd0_q[2*DW-1:DW]);
      out_im_q   <= $signed(rd0_q[DW-1:0]);
      out_last_q <= cmd_i.out_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_real_o      = out_re_q;
  assign out_imag_o      = out_im_q;
  assign last_of_frame_o = out_last_q;

endmodule
`default_nettype wire

// ===== src/fft2d_ctrl.sv =====
// Controller of the 2D FFT core: configuration registers, load count and
// the sequencer over passes, lines, stages and butterflies. Uses fft2d_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fft2d_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [1:0]       cfg_data_i,
  input  wire fft2d_pkg::stat_t stat_i,
  output fft2d_pkg::cmd_t       cmd_o
);

  localparam int PW = fft2d_pkg::POS_W;
  localparam int AW = fft2d_pkg::ADDR_W;
  localparam int CW = fft2d_pkg::CNT_W;

  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_SWP_RD = 4'd1;
  localparam logic [3:0] ST_SWP_WA = 4'd2;
  localparam logic [3:0] ST_SWP_WB = 4'd3;
  localparam logic [3:0] ST_BF_RD  = 4'd4;
  localparam logic [3:0] ST_BF_MUL = 4'd5;
  localparam logic [3:0] ST_BF_RND = 4'd6;
  localparam logic [3:0] ST_BF_WA  = 4'd7;
  localparam logic [3:0] ST_BF_WC  = 4'd8;
  localparam logic [3:0] ST_EM_RD  = 4'd9;
  localparam logic [3:0] ST_EM_OUT = 4'd10;

  logic [3:0]                     state_q, state_d;
  logic                           pass_q, pass_d;
  logic [PW-1:0]                  line_q, line_d, idx_q, idx_d;
  logic [fft2d_pkg::LOG_W-1:0]    stage_q, stage_d;
  logic [CW-1:0]                  cnt_q, cnt_d, emit_q, emit_d;
  logic                           inv_q;
  logic [fft2d_pkg::LOG_W-1:0]    wl_q, hl_q, wl, hl, lg_cur, line_log, sm1;
  logic [CW-1:0]                  size;
  logic [PW-1:0]                  n_m1, half_m1, lines_m1, rev, j, top, bot;
  logic [3:0]                     adv_state, start_state;
  logic                           adv_pass, start_pass;
  logic [PW-1:0]                  adv_line, adv_idx;
  logic [fft2d_pkg::LOG_W-1:0]    adv_stage;
  fft2d_pkg::cmd_t                cmd;

  function automatic logic [AW-1:0] elem_addr(input logic col, input logic [PW-1:0] line,
                                              input logic [PW-1:0] pos,
                                              input logic [fft2d_pkg::LOG_W-1:0] wlog);
    logic [AW-1:0] lo, hi;
    lo = col ? AW'(line) : AW'(pos);
    hi = col ? AW'(pos) : AW'(line);
    return (hi << wlog) | lo;
  endfunction

  assign wl       = fft2d_pkg::fit_log(wl_q, fft2d_pkg::WIDTH_LOG);
  assign hl       = fft2d_pkg::fit_log(hl_q, fft2d_pkg::HEIGHT_LOG);
  assign size     = CW'(1) << ({1'b0, wl} + {1'b0, hl});
  assign lg_cur   = pass_q ? hl : wl;
  assign line_log = pass_q ? wl : hl;
  assign n_m1     = PW'((4'd1 << lg_cur) - 4'd1);
  assign half_m1  = (lg_cur == '0) ? '0 : PW'((4'd1 << (lg_cur - 2'd1)) - 4'd1);
  assign lines_m1 = PW'((4'd1 << line_log) - 4'd1);
  assign rev      = fft2d_pkg::bit_rev(idx_q, lg_cur);
  assign sm1      = stage_q - 2'd1;
  assign j        = idx_q & PW'((4'd1 << sm1) - 4'd1);
  assign top      = PW'(({1'b0, idx_q} >> sm1) << stage_q) | j;
  assign bot      = top + PW'(4'd1 << sm1);

  // first pass of a frame; a pass of length one is skipped
  always_comb begin
    start_pass  = 1'b0;
    start_state = ST_SWP_RD;
    if (wl == '0) begin
      start_pass = 1'b1;
      if (hl == '0) start_state = ST_EM_RD;
    end
  end

  // advance past the current swap slot or butterfly
  always_comb begin
    adv_state = ST_BF_RD;
    adv_pass  = pass_q;
    adv_line  = line_q;
    adv_stage = stage_q;
    adv_idx   = idx_q + 1'b1;
    if (stage_q == '0) begin
      if (idx_q == n_m1) begin
        adv_stage = 2'd1;
        adv_idx   = '0;
      end else begin
        adv_state = ST_SWP_RD;
      end
    end else if (idx_q != half_m1) begin
      adv_state = ST_BF_RD;
    end else if (stage_q != lg_cur) begin
      adv_stage = stage_q + 2'd1;
      adv_idx   = '0;
    end else begin
      adv_stage = '0;
      adv_idx   = '0;
      adv_state = ST_SWP_RD;
      if (line_q != lines_m1) begin
        adv_line = line_q + 1'b1;
      end else begin
        adv_line = '0;
        if (!pass_q && hl != '0) begin
          adv_pass = 1'b1;
        end else begin
          adv_state = ST_EM_RD;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    line_d  = line_q;
    stage_d = stage_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    emit_d  = '0;
    cmd          = '0;
    cmd.wr_sel   = fft2d_pkg::WR_NONE;
    cmd.tw_idx   = 2'(j << (fft2d_pkg::TW_LOG - int'(stage_q)));
    cmd.inverse  = inv_q;
    cmd.scale_en = inv_q && (stage_q == lg_cur);
    cmd.scale_sh = lg_cur;
    in_stall_o   = 1'b1;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (cnt_q < size) begin
            cmd.wr_sel  = fft2d_pkg::WR_LOAD;
            cmd.wr_addr = cnt_q[AW-1:0];
            cnt_d       = cnt_q + 1'b1;
          end
          // a full frame, or a sample beyond a shrunk frame, starts the transform
          if (cnt_q + 1'b1 >= size) begin
            cnt_d   = '0;
            pass_d  = start_pass;
            line_d  = '0;
            stage_d = '0;
            idx_d   = '0;
            state_d = start_state;
          end
        end
      end
      ST_SWP_RD: begin
        if (rev > idx_q) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_addr0 = elem_addr(pass_q, line_q, idx_q, wl);
          cmd.rd_addr1 = elem_addr(pass_q, line_q, rev, wl);
          state_d      = ST_SWP_WA;
        end else begin
          state_d = adv_state;
          pass_d  = adv_pass;
          line_d  = adv_line;
          stage_d = adv_stage;
          idx_d   = adv_idx;
        end
      end
      ST_SWP_WA: begin
        cmd.wr_sel  = fft2d_pkg::WR_SWAP_LO;
        cmd.wr_addr = elem_addr(pass_q, line_q, idx_q, wl);
        state_d     = ST_SWP_WB;
      end
      ST_SWP_WB: begin
        cmd.wr_sel  = fft2d_pkg::WR_SWAP_HI;
        cmd.wr_addr = elem_addr(pass_q, line_q, rev, wl);
        state_d = adv_state;
        pass_d  = adv_pass;
        line_d  = adv_line;
        stage_d = adv_stage;
        idx_d   = adv_idx;
      end
      ST_BF_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_addr0 = elem_addr(pass_q, line_q, top, wl);
        cmd.rd_addr1 = elem_addr(pass_q, line_q, bot, wl);
        state_d      = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        cmd.mul_en = 1'b1;
        state_d    = ST_BF_RND;
      end
      ST_BF_RND: begin
        cmd.rnd_en = 1'b1;
        state_d    = ST_BF_WA;
      end
      ST_BF_WA: begin
        cmd.wr_sel  = fft2d_pkg::WR_BFLY_A;
        cmd.wr_addr = elem_addr(pass_q, line_q, top, wl);
        state_d     = ST_BF_WC;
      end
      ST_BF_WC: begin
        cmd.wr_sel  = fft2d_pkg::WR_BFLY_C;
        cmd.wr_addr = elem_addr(pass_q, line_q, bot, wl);
        state_d = adv_state;
        pass_d  = adv_pass;
        line_d  = adv_line;
        stage_d = adv_stage;
        idx_d   = adv_idx;
      end
      ST_EM_RD: begin
        emit_d       = emit_q;
        cmd.rd_en    = 1'b1;
        cmd.rd_addr0 = emit_q[AW-1:0];
        state_d      = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        emit_d = emit_q;
        if (stat_i.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (emit_q == size - 1'b1);
          emit_d       = emit_q + 1'b1;
          state_d      = cmd.out_last ? ST_LOAD : ST_EM_RD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      pass_q  <= 1'b0;
      line_q  <= '0;
      stage_q <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      line_q  <= line_d;
      stage_q <= stage_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      emit_q  <= emit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
      wl_q  <= 2'd3;
      hl_q  <= 2'd3;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fft2d_pkg::REG_INVERSE:    inv_q <= cfg_data_i[0];
        fft2d_pkg::REG_WIDTH_LOG:  wl_q  <= cfg_data_i;
        fft2d_pkg::REG_HEIGHT_LOG: hl_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  `ASSERT_PROP(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(fft2d_pkg::DEPTH))
  `ASSERT_PROP(a_cnt_clear, clk_i, rst_ni, (state_q != ST_LOAD) |-> (cnt_q == '0))
  `ASSERT_PROP(a_out_free, clk_i, rst_ni, cmd.out_load |-> stat_i.out_free)
  `ASSERT_PROP(a_last_ends, clk_i, rst_ni, (cmd.out_load && cmd.out_last) |=> (state_q == ST_LOAD))
  `ASSERT_NEVER(a_emit_no_wr, clk_i, rst_ni, (state_q == ST_EM_RD || state_q == ST_EM_OUT) && (cmd.wr_sel != fft2d_pkg::WR_NONE))

endmodule
`default_nettype wire

// ===== src/fft_2d_row_column_core.sv =====
// 2D radix-2 row-column FFT core in fixed point.
// Input channel: one complex sample per beat (valid/stall), row-major.
// Once a frame of 2^width_log2 x 2^height_log2 samples is held, every row and
// then every column is transformed in place in a 64-entry frame memory.
// Output channel: one complex result per beat, row-major, last_of_frame on the
// final beat. A single butterfly unit does the work: each butterfly steps through
// read, multiply, round, write top and write bottom through the one memory write
// port; bit-reversal visits every slot and swaps a pair with a read and two writes.
// Each result is read from memory, then loaded into the output register.
// Input is stalled from the frame's completing beat until the last result
// has been loaded into the output register.
// When the receiver stalls, the output register holds its beat and emission
// waits. Reset empties the load count and sets forward mode with 8x8 frames;
// frame memory contents are not cleared.
// Configuration writes take effect at once and belong between frames.
`timescale 1ns / 1ps
`default_nettype none
module fft_2d_row_column_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [fft2d_pkg::DATA_W-1:0] sample_real_i,
  input  wire logic signed [fft2d_pkg::DATA_W-1:0] sample_imag_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [fft2d_pkg::DATA_W-1:0]      out_real_o,
  output logic signed [fft2d_pkg::DATA_W-1:0]      out_imag_o,
  output logic                                     last_of_frame_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [1:0]                          cfg_data_i
);

  fft2d_pkg::cmd_t  cmd;
  fft2d_pkg::stat_t stat;

  fft2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fft2d_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .sample_real_i   (sample_real_i),
    .sample_imag_i   (sample_imag_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_real_o      (out_real_o),
    .out_imag_o      (out_imag_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule
`default_nettype wire

// ===== test/fft_2d_row_column_core_tb.sv =====
// Self-checking testbench for fft_2d_row_column_core: streams frames of complex
// samples, predicts every transformed value and checks each output beat.
// Depends on fft2d_pkg and the core RTL only.
`timescale 1ns / 1ps
module fft_2d_row_column_core_tb;

  localparam int STALL_LIMIT = 20000;
  localparam int RAND_ITEMS  = 250;
  localparam int QUIET_FROM  = 200;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               last;
  } bin_t;

  typedef struct {
    bit                 inv;
    logic [1:0]         wl;
    logic [1:0]         hl;
    logic signed [31:0] re;
    logic signed [31:0] im;
    bit                 typed;
    logic signed [31:0] exp_re;
    logic signed [31:0] exp_im;
  } vec_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_re = '0;
  logic signed [31:0] in_im = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_re;
  logic signed [31:0] out_im;
  logic               out_last;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [1:0]         cfg_data = '0;

  // predictor state
  longint frame_re[64];
  longint frame_im[64];
  int     load_cnt;
  bit     inv_mode;
  int     w_log;
  int     h_log;

  bin_t   pending_bins[$];
  int     mismatch_count;
  int     quiet_cycles;
  bit     quiet;
  int     items_sent;

  fft_2d_row_column_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_real_i  (in_re),
    .sample_imag_i  (in_im),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_real_o     (out_re),
    .out_imag_o     (out_im),
    .last_of_frame_o(out_last),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint rnd_shift(longint v, int s);
    longint q;
    q = v + (longint'(1) << (s - 1));
    return q >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void fft_line(inout longint re[8], inout longint im[8], input int lg,
                                   input bit inv);
    longint tw_c[4] = '{65536, 46341, 0, -46341};
    longint tw_s[4] = '{0, -46341, -65536, -46341};
    int n, r, t, idx, m, h;
    longint wr, wi, tr, ti, ur, ui, tmp;
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      r = 0;
      t = i;
      for (int b = 0; b < lg; b++) begin
        r = (r << 1) | (t & 1);
        t = t >> 1;
      end
      if (r > i) begin
        tmp = re[i]; re[i] = re[r]; re[r] = tmp;
        tmp = im[i]; im[i] = im[r]; im[r] = tmp;
      end
    end
    for (int s = 1; s <= lg; s++) begin
      m = 1 << s;
      h = m >> 1;
      for (int k = 0; k < n; k += m) begin
        for (int j = 0; j < h; j++) begin
          idx = (j << (3 - s)) & 3;
          wr = tw_c[idx];
          wi = inv ? -tw_s[idx] : tw_s[idx];
          tr = rnd_shift(wr * re[k+j+h] - wi * im[k+j+h], 16);
          ti = rnd_shift(wr * im[k+j+h] + wi * re[k+j+h], 16);
          ur = re[k+j];
          ui = im[k+j];
          re[k+j] = clamp32(ur + tr);
          im[k+j] = clamp32(ui + ti);
          re[k+j+h] = clamp32(ur - tr);
          im[k+j+h] = clamp32(ui - ti);
        end
      end
    end
    if (inv && lg > 0) begin
      for (int i = 0; i < n; i++) begin
        re[i] = rnd_shift(re[i], lg);
        im[i] = rnd_shift(im[i], lg);
      end
    end
  endfunction

  // take one sample; on the frame's final beat transform and queue the whole frame
  function automatic void absorb_sample(logic signed [31:0] re, logic signed [31:0] im);
    int w, h, size;
    longint lre[8];
    longint lim[8];
    bin_t b;
    w = 1 << w_log;
    h = 1 << h_log;
    size = w * h;
    frame_re[load_cnt] = re;
    frame_im[load_cnt] = im;
    load_cnt++;
    if (load_cnt < size) return;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        lre[c] = frame_re[r*w+c];
        lim[c] = frame_im[r*w+c];
      end
      fft_line(lre, lim, w_log, inv_mode);
      for (int c = 0; c < w; c++) begin
        frame_re[r*w+c] = lre[c];
        frame_im[r*w+c] = lim[c];
      end
    end
    for (int c = 0; c < w; c++) begin
      for (int r = 0; r < h; r++) begin
        lre[r] = frame_re[r*w+c];
        lim[r] = frame_im[r*w+c];
      end
      fft_line(lre, lim, h_log, inv_mode);
      for (int r = 0; r < h; r++) begin
        frame_re[r*w+c] = lre[r];
        frame_im[r*w+c] = lim[r];
      end
    end
    for (int i = 0; i < size; i++) begin
      b.re = frame_re[i][31:0];
      b.im = frame_im[i][31:0];
      b.last = (i == size - 1);
      pending_bins.push_back(b);
    end
    load_cnt = 0;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // wait for all bins, let the core settle, then rewrite every register
  task automatic set_config(bit inv, logic [1:0] wl, logic [1:0] hl);
    logic [1:0] vals[3];
    logic [1:0] idxs[3];
    vals = '{logic'(inv), wl, hl};
    idxs = '{fft2d_pkg::REG_INVERSE, fft2d_pkg::REG_WIDTH_LOG, fft2d_pkg::REG_HEIGHT_LOG};
    in_valid = 1'b0;
    while (pending_bins.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_we = 1'b1;
      cfg_index = idxs[i];
      cfg_data = vals[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
    inv_mode = inv;
    w_log = wl;
    h_log = hl;
  endtask

  task automatic send_sample(logic signed [31:0] re, logic signed [31:0] im);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_re = re;
    in_im = im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_sample(re, im);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 4095) - 2048;
      1: return 32'sh7FFFFFFF - $urandom_range(0, 3);
      2: return 32'sh80000000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // receiver stalls in bursts
  int stall_left = 0;
  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    bin_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bins.size() == 0) begin
        report("unexpected beat", out_re, 0);
      end else begin
        want = pending_bins.pop_front();
        if (out_re !== want.re) report("out_real", out_re, want.re);
        if (out_im !== want.im) report("out_imag", out_im, want.im);
        if (out_last !== want.last) report("last_of_frame", out_last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  vec_t directed[] = '{
    // single-sample frames pass through untouched
    '{0, 2'd0, 2'd0, 32'sh7FFFFFFF, 32'sh80000000, 1, 32'sh7FFFFFFF, 32'sh80000000},
    '{0, 2'd0, 2'd0, 32'sh80000000, 32'sh7FFFFFFF, 1, 32'sh80000000, 32'sh7FFFFFFF},
    '{0, 2'd0, 2'd0, 32'sd0, -32'sd1, 1, 32'sd0, -32'sd1},
    '{1, 2'd0, 2'd0, 32'sd1, 32'sd256, 1, 32'sd1, 32'sd256},
    // saturating butterflies
    '{0, 2'd1, 2'd0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0},
    '{0, 2'd1, 2'd0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0},
    '{0, 2'd0, 2'd1, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0},
    '{0, 2'd0, 2'd1, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0},
    // inverse with rounding on a 2x2 frame
    '{1, 2'd1, 2'd1, 32'sd3, -32'sd3, 0, 0, 0},
    '{1, 2'd1, 2'd1, 32'sd1, 32'sd2, 0, 0, 0},
    '{1, 2'd1, 2'd1, -32'sd1, 32'sd5, 0, 0, 0},
    '{1, 2'd1, 2'd1, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0},
    // 4x2 forward, exercises the quarter twiddles
    '{0, 2'd2, 2'd1, 32'sd1000, 32'sd0, 0, 0, 0},
    '{0, 2'd2, 2'd1, -32'sd77, 32'sd300, 0, 0, 0},
    '{0, 2'd2, 2'd1, 32'sd12345, -32'sd999, 0, 0, 0},
    '{0, 2'd2, 2'd1, 32'sd5, 32'sd6, 0, 0, 0},
    '{0, 2'd2, 2'd1, 32'sh7FFFFFFF, 32'sd0, 0, 0, 0},
    '{0, 2'd2, 2'd1, 32'sd0, 32'sh80000000, 0, 0, 0},
    '{0, 2'd2, 2'd1, -32'sd1, -32'sd1, 0, 0, 0},
    '{0, 2'd2, 2'd1, 32'sd256, 32'sd256, 0, 0, 0}
  };

  initial begin
    logic [1:0] wl, hl;
    bit         inv;
    int         frames;
    mismatch_count = 0;
    quiet_cycles = 0;
    quiet = 1'b0;
    items_sent = 0;
    load_cnt = 0;
    inv_mode = 1'b0;
    w_log = 3;
    h_log = 3;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < directed.size(); i++) begin
      if (i == 0 || directed[i].inv != inv_mode || directed[i].wl != w_log ||
          directed[i].hl != h_log) begin
        set_config(directed[i].inv, directed[i].wl, directed[i].hl);
      end
      send_sample(directed[i].re, directed[i].im);
      if (directed[i].typed) begin
        pending_bins[$].re = directed[i].exp_re;
        pending_bins[$].im = directed[i].exp_im;
      end
    end

    items_sent = 0;
    for (int phase = 0; items_sent < RAND_ITEMS; phase++) begin
      case (phase)
        0: begin inv = 0; wl = 3; hl = 3; end
        1: begin inv = 1; wl = 3; hl = 3; end
        2: begin inv = 0; wl = 3; hl = 0; end
        3: begin inv = 1; wl = 0; hl = 3; end
        default: begin
          inv = $urandom_range(0, 1);
          wl = $urandom_range(0, 3);
          hl = $urandom_range(0, 3);
        end
      endcase
      set_config(inv, wl, hl);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames && items_sent < RAND_ITEMS; f++) begin
        for (int k = 0; k < (1 << (int'(wl) + int'(hl))); k++) begin
          if (items_sent >= QUIET_FROM) quiet = 1'b1;
          send_sample(pick_value(), pick_value());
        end
      end
    end
    in_valid = 1'b0;

    while (pending_bins.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
